[rtl/ttl_pkg.sv]
// Shared types and constants for the thermal throttle level controller.
// No dependencies; every other file refers to this package by scoped names.
package ttl_pkg;

  localparam int TEMP_BITS      = 10;
  localparam int FREQ_BITS      = 22;
  localparam int TIME_BITS      = 32;
  localparam int ELAPSED_BITS   = 16;
  localparam int LEVEL_BITS     = 2;
  localparam int CFG_INDEX_BITS = 3;
  localparam int BAND_BITS      = 2 * TEMP_BITS;
  localparam int CFG_DATA_BITS  = (BAND_BITS > FREQ_BITS) ? BAND_BITS : FREQ_BITS;

  // Register indexes on the configuration channel
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SHUT_LIMIT    = 3'd0,
    REG_LOW_BAND      = 3'd1,
    REG_MID_BAND      = 3'd2,
    REG_MAX_BAND      = 3'd3,
    REG_LOW_CAP_FREQ  = 3'd4,
    REG_MID_CAP_FREQ  = 3'd5,
    REG_MAX_CAP_FREQ  = 3'd6,
    REG_FALLBACK_FREQ = 3'd7
  } cfg_reg_t;

  typedef enum logic [LEVEL_BITS-1:0] {
    LEVEL_NONE = 2'd0,
    LEVEL_LOW  = 2'd1,
    LEVEL_MID  = 2'd2,
    LEVEL_MAX  = 2'd3
  } level_t;

  typedef struct packed {
    logic [TEMP_BITS-1:0] shut_limit;
    logic [TEMP_BITS-1:0] low_trip;
    logic [TEMP_BITS-1:0] low_clear;
    logic [TEMP_BITS-1:0] mid_trip;
    logic [TEMP_BITS-1:0] mid_clear;
    logic [TEMP_BITS-1:0] max_trip;
    logic [TEMP_BITS-1:0] max_clear;
    logic [FREQ_BITS-1:0] low_cap_freq;
    logic [FREQ_BITS-1:0] mid_cap_freq;
    logic [FREQ_BITS-1:0] max_cap_freq;
    logic [FREQ_BITS-1:0] fallback_freq;
  } cfg_t;

  typedef struct packed {
    logic [TEMP_BITS-1:0]    temp_sample;
    logic                    sample_valid;
    logic [FREQ_BITS-1:0]    current_ceiling;
    logic [ELAPSED_BITS-1:0] elapsed_ms;
  } sample_t;

  typedef struct packed {
    level_t               level;
    logic [FREQ_BITS-1:0] saved_ceiling;
    logic [TIME_BITS-1:0] low_time;
    logic [TIME_BITS-1:0] mid_time;
    logic [TIME_BITS-1:0] max_time;
  } state_t;

  typedef struct packed {
    level_t               level;
    logic                 apply_cap;
    logic [FREQ_BITS-1:0] cap_freq;
    logic                 shutdown_request;
    logic                 wake_cores;
    logic [TIME_BITS-1:0] time_low_ms;
    logic [TIME_BITS-1:0] time_mid_ms;
    logic [TIME_BITS-1:0] time_max_ms;
  } result_t;

endpackage

[rtl/ttl_if.sv]
// Valid/ready channel interfaces: temperature samples, throttle results and
// configuration writes. Depends on ttl_pkg for field widths.
interface ttl_sample_if;
  logic                             valid;
  logic                             ready;
  logic [ttl_pkg::TEMP_BITS-1:0]    temp_sample;
  logic                             sample_valid;
  logic [ttl_pkg::FREQ_BITS-1:0]    current_ceiling;
  logic [ttl_pkg::ELAPSED_BITS-1:0] elapsed_ms;

  modport source (output valid, temp_sample, sample_valid, current_ceiling, elapsed_ms,
                  input ready);
  modport sink (input valid, temp_sample, sample_valid, current_ceiling, elapsed_ms,
                output ready);
endinterface

interface ttl_result_if;
  logic                           valid;
  logic                           ready;
  logic [ttl_pkg::LEVEL_BITS-1:0] level;
  logic                           apply_cap;
  logic [ttl_pkg::FREQ_BITS-1:0]  cap_freq;
  logic                           shutdown_request;
  logic                           wake_cores;
  logic [ttl_pkg::TIME_BITS-1:0]  time_low_ms;
  logic [ttl_pkg::TIME_BITS-1:0]  time_mid_ms;
  logic [ttl_pkg::TIME_BITS-1:0]  time_max_ms;

  modport source (output valid, level, apply_cap, cap_freq, shutdown_request, wake_cores,
                  time_low_ms, time_mid_ms, time_max_ms, input ready);
  modport sink (input valid, level, apply_cap, cap_freq, shutdown_request, wake_cores,
                time_low_ms, time_mid_ms, time_max_ms, output ready);
endinterface

interface ttl_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ttl_pkg::CFG_INDEX_BITS-1:0] index;
  logic [ttl_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/ttl_cfg_regs.sv]
// Configuration register file: thresholds, band splits and frequency ceilings.
// Depends on ttl_pkg and ttl_if (ttl_cfg_if).
module ttl_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  ttl_cfg_if.sink       cfg,
  output ttl_pkg::cfg_t regs
);

  // Writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.shut_limit    <= '1;
      regs.low_trip      <= '0;
      regs.low_clear     <= '0;
      regs.mid_trip      <= '0;
      regs.mid_clear     <= '0;
      regs.max_trip      <= '0;
      regs.max_clear     <= '0;
      regs.low_cap_freq  <= '0;
      regs.mid_cap_freq  <= '0;
      regs.max_cap_freq  <= '0;
      regs.fallback_freq <= '0;
    end else if (cfg.valid) begin
      unique case (ttl_pkg::cfg_reg_t'(cfg.index))
        ttl_pkg::REG_SHUT_LIMIT: regs.shut_limit <= cfg.data[ttl_pkg::TEMP_BITS-1:0];
        ttl_pkg::REG_LOW_BAND: begin
          regs.low_trip  <= cfg.data[ttl_pkg::TEMP_BITS-1:0];
          regs.low_clear <= cfg.data[ttl_pkg::BAND_BITS-1:ttl_pkg::TEMP_BITS];
        end
        ttl_pkg::REG_MID_BAND: begin
          regs.mid_trip  <= cfg.data[ttl_pkg::TEMP_BITS-1:0];
          regs.mid_clear <= cfg.data[ttl_pkg::BAND_BITS-1:ttl_pkg::TEMP_BITS];
        end
        ttl_pkg::REG_MAX_BAND: begin
          regs.max_trip  <= cfg.data[ttl_pkg::TEMP_BITS-1:0];
          regs.max_clear <= cfg.data[ttl_pkg::BAND_BITS-1:ttl_pkg::TEMP_BITS];
        end
        ttl_pkg::REG_LOW_CAP_FREQ:  regs.low_cap_freq  <= cfg.data[ttl_pkg::FREQ_BITS-1:0];
        ttl_pkg::REG_MID_CAP_FREQ:  regs.mid_cap_freq  <= cfg.data[ttl_pkg::FREQ_BITS-1:0];
        ttl_pkg::REG_MAX_CAP_FREQ:  regs.max_cap_freq  <= cfg.data[ttl_pkg::FREQ_BITS-1:0];
        ttl_pkg::REG_FALLBACK_FREQ: regs.fallback_freq <= cfg.data[ttl_pkg::FREQ_BITS-1:0];
      endcase
    end
  end

endmodule

[rtl/ttl_decide.sv]
// Combinational throttle decision: time accounting, shutdown forcing, ceiling
// save and the trip/clear priority chain. Depends on ttl_pkg.
module ttl_decide (
  input  ttl_pkg::sample_t smp,
  input  ttl_pkg::state_t  cur,
  input  ttl_pkg::cfg_t    regs,
  output ttl_pkg::state_t  nxt,
  output ttl_pkg::result_t res
);

  logic [ttl_pkg::TIME_BITS:0]     low_sum;
  logic [ttl_pkg::TIME_BITS:0]     mid_sum;
  logic [ttl_pkg::TIME_BITS:0]     max_sum;
  logic [ttl_pkg::TIME_BITS-1:0]   low_time_next;
  logic [ttl_pkg::TIME_BITS-1:0]   mid_time_next;
  logic [ttl_pkg::TIME_BITS-1:0]   max_time_next;
  logic [ttl_pkg::TEMP_BITS-1:0]   t;
  logic                            shut;
  ttl_pkg::level_t                 lv;
  logic [ttl_pkg::FREQ_BITS-1:0]   saved;
  ttl_pkg::level_t                 lv_next;
  logic                            apply;
  logic                            wake;
  logic [ttl_pkg::FREQ_BITS-1:0]   cap;

  // Elapsed time goes to the level held before this sample, saturating
  assign low_sum = {1'b0, cur.low_time} + {{(ttl_pkg::TIME_BITS + 1 - ttl_pkg::ELAPSED_BITS){1'b0}},
                                          smp.elapsed_ms};
  assign mid_sum = {1'b0, cur.mid_time} + {{(ttl_pkg::TIME_BITS + 1 - ttl_pkg::ELAPSED_BITS){1'b0}},
                                          smp.elapsed_ms};
  assign max_sum = {1'b0, cur.max_time} + {{(ttl_pkg::TIME_BITS + 1 - ttl_pkg::ELAPSED_BITS){1'b0}},
                                          smp.elapsed_ms};

  always_comb begin
    low_time_next = cur.low_time;
    mid_time_next = cur.mid_time;
    max_time_next = cur.max_time;
    unique case (cur.level)
      ttl_pkg::LEVEL_LOW: low_time_next = low_sum[ttl_pkg::TIME_BITS] ? '1 :
                                          low_sum[ttl_pkg::TIME_BITS-1:0];
      ttl_pkg::LEVEL_MID: mid_time_next = mid_sum[ttl_pkg::TIME_BITS] ? '1 :
                                          mid_sum[ttl_pkg::TIME_BITS-1:0];
      ttl_pkg::LEVEL_MAX: max_time_next = max_sum[ttl_pkg::TIME_BITS] ? '1 :
                                          max_sum[ttl_pkg::TIME_BITS-1:0];
      ttl_pkg::LEVEL_NONE: ;
    endcase
  end

  assign nxt.low_time = low_time_next;
  assign nxt.mid_time = mid_time_next;
  assign nxt.max_time = max_time_next;

  // Shutdown forcing and pre-throttle ceiling save
  assign t     = smp.temp_sample;
  assign shut  = smp.sample_valid && (t >= regs.shut_limit);
  assign lv    = shut ? ttl_pkg::LEVEL_MAX : cur.level;
  assign saved = (lv == ttl_pkg::LEVEL_NONE) ? smp.current_ceiling : cur.saved_ceiling;

  // Trip/clear chain, first match wins
  always_comb begin
    lv_next = lv;
    apply   = 1'b0;
    wake    = 1'b0;
    cap     = '0;
    priority if (t >= regs.low_trip && t < regs.mid_trip && lv == ttl_pkg::LEVEL_NONE) begin
      apply = 1'b1; cap = regs.low_cap_freq; lv_next = ttl_pkg::LEVEL_LOW;
    end else if (t < regs.low_clear && lv != ttl_pkg::LEVEL_NONE) begin
      apply = 1'b1; wake = 1'b1; lv_next = ttl_pkg::LEVEL_NONE;
      cap = (saved != '0) ? saved : regs.fallback_freq;
    end else if (t >= regs.mid_trip && t < regs.max_trip && lv <= ttl_pkg::LEVEL_LOW) begin
      apply = 1'b1; cap = regs.mid_cap_freq; lv_next = ttl_pkg::LEVEL_MID;
    end else if (t < regs.mid_clear && lv >= ttl_pkg::LEVEL_MID) begin
      apply = 1'b1; cap = regs.low_cap_freq; lv_next = ttl_pkg::LEVEL_LOW;
    end else if (t >= regs.max_trip) begin
      apply = 1'b1; cap = regs.max_cap_freq; lv_next = ttl_pkg::LEVEL_MAX;
    end else if (t < regs.max_clear && lv == ttl_pkg::LEVEL_MAX) begin
      apply = 1'b1; cap = regs.mid_cap_freq; lv_next = ttl_pkg::LEVEL_MID;
    end else if (shut) begin
      apply = 1'b1; cap = regs.max_cap_freq;
    end else begin
      apply = 1'b0;
    end
  end

  // An invalid sample leaves level and saved ceiling alone and decides nothing
  assign nxt.level         = smp.sample_valid ? lv_next : cur.level;
  assign nxt.saved_ceiling = smp.sample_valid ? saved : cur.saved_ceiling;

  assign res.level            = nxt.level;
  assign res.apply_cap        = smp.sample_valid && apply;
  assign res.cap_freq         = smp.sample_valid ? cap : '0;
  assign res.shutdown_request = shut;
  assign res.wake_cores       = smp.sample_valid && wake;
  assign res.time_low_ms      = low_time_next;
  assign res.time_mid_ms      = mid_time_next;
  assign res.time_max_ms      = max_time_next;

endmodule

[rtl/thermal_throttle_level_control.sv]
// Top level of the thermal throttle level controller.
// Depends on ttl_pkg, ttl_if, ttl_cfg_regs and ttl_decide.
//
// One temperature sample in, one result out. A sample is captured in an input
// register at its transfer and decided combinationally against the throttle
// state; the result register is written when the stage advances, and the
// result is offered from there. A new sample can be taken every cycle unless
// the input register stalls; the throttle state register closes its loop
// through the combinational decision alone. The input register only stalls
// when it is full and the result waits. Write configuration only while no
// sample is in flight; writes are always taken and the register file resets
// to shutdown at full scale, all else zero.
module thermal_throttle_level_control (
  input  logic         clk,
  input  logic         rst,
  ttl_sample_if.sink   sample,
  ttl_result_if.source result,
  ttl_cfg_if.sink      cfg
);

  ttl_pkg::cfg_t    regs;
  logic             s1_valid;
  ttl_pkg::sample_t s1_sample;
  ttl_pkg::state_t  state;
  ttl_pkg::state_t  state_next;
  ttl_pkg::result_t res_next;
  logic             out_valid;
  ttl_pkg::result_t out_data;
  logic             advance;

  ttl_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ttl_decide u_decide (
    .smp  (s1_sample),
    .cur  (state),
    .regs (regs),
    .nxt  (state_next),
    .res  (res_next)
  );

  // Stage moves when the result register is empty or being drained
  assign advance      = !out_valid || result.ready;
  assign sample.ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_sample.temp_sample     <= sample.temp_sample;
      s1_sample.sample_valid    <= sample.sample_valid;
      s1_sample.current_ceiling <= sample.current_ceiling;
      s1_sample.elapsed_ms      <= sample.elapsed_ms;
    end
  end

  // Throttle state, updated once per decided sample
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_valid && advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      out_data <= res_next;
    end
  end

  assign result.valid            = out_valid;
  assign result.level            = out_data.level;
  assign result.apply_cap        = out_data.apply_cap;
  assign result.cap_freq         = out_data.cap_freq;
  assign result.shutdown_request = out_data.shutdown_request;
  assign result.wake_cores       = out_data.wake_cores;
  assign result.time_low_ms      = out_data.time_low_ms;
  assign result.time_mid_ms      = out_data.time_mid_ms;
  assign result.time_max_ms      = out_data.time_max_ms;

  // Level only moves when a sample is decided
  a_level_hold: assert property (@(posedge clk) disable iff (rst)
    !(s1_valid && advance) |=> $stable(state.level))
    else $error("throttle level changed without a decided sample");

  // A shutdown request always comes with a ceiling to apply
  a_shutdown_cap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.shutdown_request) |-> out_data.apply_cap)
    else $error("shutdown request without a ceiling to apply");

  // Waking cores only comes with a cap restore to level none
  a_wake_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.wake_cores) |->
      (out_data.apply_cap && out_data.level == ttl_pkg::LEVEL_NONE))
    else $error("wake_cores without a restore to level none");

  // Time counters never run backwards
  a_time_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (state.low_time >= $past(state.low_time) &&
                     state.mid_time >= $past(state.mid_time) &&
                     state.max_time >= $past(state.max_time)))
    else $error("level time counter decreased");

endmodule
